### hdl/path_node_interval_key_top_defines.svh
// Assertion macros for the node interval key block
`ifndef PATH_NODE_INTERVAL_KEY_TOP_DEFINES_SVH
`define PATH_NODE_INTERVAL_KEY_TOP_DEFINES_SVH

// checked outside reset
`define PNIK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pnik assertion failed");

// checked during reset as well
`define PNIK_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pnik assertion failed during reset");

`endif

### hdl/pnik_pkg.sv
`default_nettype none
package pnik_pkg;
	localparam int ID_W    = 32;
	localparam int HALF_W  = 32;
	localparam int KEY_W   = 64;
	localparam int COL_W   = 5;
	localparam int PATH_W  = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};
	localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

	localparam logic [7:0] BYTE_TAB = 8'd9;
	localparam logic [7:0] BYTE_NL  = 8'd10;
	localparam logic [7:0] BYTE_D0  = 8'd48;
	localparam logic [7:0] BYTE_D9  = 8'd57;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_FIELD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISSING_KEY = 2'd2;

	localparam logic [PATH_W-1:0] PATH_FIELD_RST = 4'd5;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_START,
		PH_DIGITS
	} phase_t;
endpackage
`default_nettype wire

### hdl/path_node_interval_key_top.sv
// A newline byte enters the input register, and its key then enters the result register.
// Throughput: one byte per cycle; the input stalls only while a newline sits in
// the input register behind a result held by out_stall.
// Reset: arst_n clears all line state and loads key_mode 1, path_field_index 5 and
// missing_key_value all ones; line state also clears after every newline.
`default_nettype none
module path_node_interval_key_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [7:0]                           text_byte,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [pnik_pkg::KEY_W-1:0]                sort_key,
	output logic                                      key_missing,
	input  wire logic                                 cfg_we,
	input  wire logic [pnik_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pnik_pkg::KEY_W-1:0]           cfg_data
);
	localparam int ID_W = pnik_pkg::ID_W;
	localparam int ACC_W = ID_W + 4;

	logic                          key_mode_q;
	logic [pnik_pkg::PATH_W-1:0]   path_idx_q;
	logic [pnik_pkg::KEY_W-1:0]    missing_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [pnik_pkg::COL_W-1:0] col_q, col_c;
	pnik_pkg::phase_t           phase_q, phase_c;
	logic [ID_W-1:0]            acc_q, acc_c;
	logic                       ovf_q, ovf_c;
	logic [ID_W-1:0]            min_q, min_c;
	logic [ID_W-1:0]            max_q, max_c;
	logic                       err_q, err_c;

	logic              out_valid_q;
	logic [pnik_pkg::KEY_W-1:0] key_q;
	logic              missing_flag_q;

	logic             is_nl, is_tab, is_digit, here, commit, advance, proc, miss_c;
	logic [3:0]       digit;
	logic [ACC_W-1:0] acc_ext, acc_next;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= 1'b1;
			path_idx_q <= pnik_pkg::PATH_FIELD_RST;
			missing_q  <= {pnik_pkg::KEY_W{1'b1}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				pnik_pkg::CFG_KEY_MODE:    key_mode_q <= cfg_data[0];
				pnik_pkg::CFG_PATH_FIELD:  path_idx_q <= cfg_data[pnik_pkg::PATH_W-1:0];
				pnik_pkg::CFG_MISSING_KEY: missing_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_nl    = (byte_s1 == pnik_pkg::BYTE_NL);
	assign is_tab   = (byte_s1 == pnik_pkg::BYTE_TAB);
	assign is_digit = (byte_s1 >= pnik_pkg::BYTE_D0) && (byte_s1 <= pnik_pkg::BYTE_D9);
	assign digit    = byte_s1[3:0];
	assign here     = (col_q == {1'b0, path_idx_q}) && !err_q;

	assign advance  = !(is_nl && out_valid_q && out_stall);
	assign proc     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign acc_ext  = {4'b0, acc_q};
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{ID_W{1'b0}}, digit};

	// id ends on any non-digit while digits are running
	assign commit = here && (phase_q == pnik_pkg::PH_DIGITS) && (is_nl || is_tab || !is_digit);

	// next phase
	always_comb begin
		phase_c = phase_q;
		if (commit) begin
			phase_c = pnik_pkg::PH_START;
		end else if (here && !is_nl && !is_tab) begin
			unique case (phase_q)
				pnik_pkg::PH_SKIP:   phase_c = pnik_pkg::PH_START;
				pnik_pkg::PH_START:  phase_c = is_digit ? pnik_pkg::PH_DIGITS : pnik_pkg::PH_START;
				pnik_pkg::PH_DIGITS: phase_c = pnik_pkg::PH_DIGITS;
				default:             phase_c = pnik_pkg::PH_SKIP;
			endcase
		end
	end

	// datapath
	always_comb begin
		col_c = col_q;
		acc_c = acc_q;
		ovf_c = ovf_q;
		min_c = min_q;
		max_c = max_q;
		err_c = err_q;
		if (is_tab && col_q != pnik_pkg::COL_MAX) begin
			col_c = col_q + 1'b1;
		end
		if (commit) begin
			if (ovf_q) begin
				err_c = 1'b1;
			end else begin
				if (acc_q < min_q) min_c = acc_q;
				if (acc_q > max_q) max_c = acc_q;
			end
			acc_c = '0;
			ovf_c = 1'b0;
		end else if (here && !is_nl && !is_tab) begin
			if (phase_q == pnik_pkg::PH_START) begin
				if (is_digit) begin
					acc_c = {{(ID_W-4){1'b0}}, digit};
					ovf_c = 1'b0;
				end else begin
					err_c = 1'b1;
				end
			end else if (phase_q == pnik_pkg::PH_DIGITS && is_digit && !ovf_q) begin
				if (acc_next[ACC_W-1:ID_W] != '0) begin
					ovf_c = 1'b1;
					err_c = 1'b1;
				end else begin
					acc_c = acc_next[ID_W-1:0];
				end
			end
		end
	end

	assign miss_c = !key_mode_q || err_c || (min_c == pnik_pkg::ID_MAX);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= pnik_pkg::PH_SKIP;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			min_q   <= pnik_pkg::ID_MAX;
			max_q   <= '0;
			err_q   <= 1'b0;
		end else if (proc) begin
			if (is_nl) begin
				col_q   <= '0;
				phase_q <= pnik_pkg::PH_SKIP;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				min_q   <= pnik_pkg::ID_MAX;
				max_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				col_q   <= col_c;
				phase_q <= phase_c;
				acc_q   <= acc_c;
				ovf_q   <= ovf_c;
				min_q   <= min_c;
				max_q   <= max_c;
				err_q   <= err_c;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && is_nl) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && is_nl) begin
			key_q          <= miss_c ? missing_q
				: {pnik_pkg::HALF_W'(min_c), pnik_pkg::HALF_W'(max_c)};
			missing_flag_q <= miss_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign sort_key    = key_q;
	assign key_missing = missing_flag_q;
endmodule
`default_nettype wire

### hdl/pnik_checker.sv
`default_nettype none
`include "path_node_interval_key_top_defines.svh"
module pnik_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [pnik_pkg::KEY_W-1:0]     sort_key,
	input wire logic                           key_missing
);
	`PNIK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(sort_key))
	`PNIK_ASSERT(a_flag_hold, out_valid && out_stall |=> $stable(key_missing))
	`PNIK_ASSERT(a_min_le_max, out_valid && !key_missing |-> sort_key[63:32] <= sort_key[31:0])
	`PNIK_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
	`PNIK_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !out_valid && !in_stall)
endmodule

bind path_node_interval_key_top pnik_checker u_pnik_checker (.*);
`default_nettype wire
